[hw/rtl/line_follow_pd_steering_macros.svh]
// assertion macros for the line follower steering block
// used by the top level only; needs clk and rst in the including scope
`ifndef LINE_FOLLOW_PD_STEERING_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_MACROS_SVH

// same-cycle implication
`define LFPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lfps_pkg.sv]
// shared widths, codes and the sensor error table for the steering block
// no dependencies; used by lfps_mac and line_follow_pd_steering
package lfps_pkg;

  localparam int ERR_W   = 11;  // error, signed q.8
  localparam int DERR_W  = 12;  // error change, signed q.8
  localparam int OPA_W   = 9;   // gain as signed operand
  localparam int ACC_W   = 22;  // pd sum, signed q.8
  localparam int SPEED_W = 11;
  localparam int BASE_W  = 10;
  localparam int GAIN_W  = 8;
  localparam int LIM_W   = 10;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 10;

  localparam logic [1:0] ACT_TRACK = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_LOST  = 2'd2;

  localparam logic [CIDX_W-1:0] REG_BASE  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PGAIN = 3'd1;
  localparam logic [CIDX_W-1:0] REG_DGAIN = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LIMIT = 3'd3;

  localparam logic [BASE_W-1:0] BASE_RESET  = 10'd300;
  localparam logic [GAIN_W-1:0] PGAIN_RESET = 8'd20;
  localparam logic [GAIN_W-1:0] DGAIN_RESET = 8'd15;
  localparam logic [LIM_W-1:0]  LIMIT_RESET = 10'd150;

  // weighted position over active count, q.8, truncated toward zero
  function automatic logic signed [ERR_W-1:0] active_error(input logic [4:0] active);
    logic [2:0] cnt;
    logic signed [3:0] sum;
    logic signed [ERR_W-1:0] sum_ext;
    logic signed [ERR_W-1:0] q;
    cnt = {2'b00, active[0]} + {2'b00, active[1]} + {2'b00, active[2]}
        + {2'b00, active[3]} + {2'b00, active[4]};
    sum = 4'sd0;
    if (active[0]) sum = sum - 4'sd3;
    if (active[1]) sum = sum - 4'sd1;
    if (active[3]) sum = sum + 4'sd1;
    if (active[4]) sum = sum + 4'sd3;
    sum_ext = {{(ERR_W-4){sum[3]}}, sum};
    case (cnt)
      3'd1: q = sum_ext <<< 8;
      3'd2: q = sum_ext <<< 7;
      3'd4: q = sum_ext <<< 6;
      3'd3: begin
        case (sum)
          4'sd4:   q = 11'sd341;
          4'sd3:   q = 11'sd256;
          4'sd2:   q = 11'sd170;
          4'sd1:   q = 11'sd85;
          -4'sd1:  q = -11'sd85;
          -4'sd2:  q = -11'sd170;
          -4'sd3:  q = -11'sd256;
          -4'sd4:  q = -11'sd341;
          default: q = 11'sd0;
        endcase
      end
      default: q = 11'sd0;
    endcase
    return q;
  endfunction

endpackage

[hw/rtl/lfps_mac.sv]
// shared multiply-accumulate unit for the pd terms
// depends on lfps_pkg for operand and accumulator widths
module lfps_mac (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                clear,
  input  logic signed [lfps_pkg::OPA_W-1:0]   mul_a,
  input  logic signed [lfps_pkg::DERR_W-1:0]  mul_b,
  output logic signed [lfps_pkg::ACC_W-1:0]   acc
);

  logic signed [lfps_pkg::OPA_W+lfps_pkg::DERR_W-1:0] prod;
  logic signed [lfps_pkg::ACC_W-1:0] acc_next;

  assign prod = mul_a * mul_b;
  assign acc_next = (clear ? '0 : acc)
                  + {{(lfps_pkg::ACC_W-lfps_pkg::OPA_W-lfps_pkg::DERR_W){prod[$high(prod)]}},
                     prod};

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= acc_next;
    end
  end

endmodule

[hw/rtl/line_follow_pd_steering.sv]
// top level of the five-sensor line follower pd steering block
// depends on lfps_pkg, lfps_mac and line_follow_pd_steering_macros.svh
//
// usage:
//   sensor request: sensor_levels with in_valid/in_ready; a low pin means
//   that sensor sees the line. one result request per sample on
//   left_speed/right_speed/action with out_valid/out_ready. config: the user
//   writes cfg_write with cfg_index/cfg_data only while idle, not enforced;
//   index 0 base speed, 1 proportional gain, 2 derivative gain, 3 diff limit.
// sequencing:
//   out_valid rises after a tracking sample has passed all steps: the two pd
//   products go one after the other through the single shared multiplier,
//   then a clamp step, a speed step and the output load. full-line and
//   line-lost samples go straight from accept to the output load. in_ready
//   is high only while the sequencer is idle, so a new sample is taken only
//   once the last one has left its last step; the next one can be taken
//   while the last result still sits in the output register.
// reset and stall:
//   rst (synchronous) restores default gains, clears previous error and held
//   speeds and drops out_valid. if the receiver stalls, the finished sample
//   waits in its last step until the output register is free.
module line_follow_pd_steering (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [4:0]                        sensor_levels,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lfps_pkg::SPEED_W-1:0]      left_speed,
  output logic [lfps_pkg::SPEED_W-1:0]      right_speed,
  output logic [1:0]                        action,
  input  logic                              cfg_write,
  input  logic [lfps_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [lfps_pkg::CDATA_W-1:0]      cfg_data
);

  `include "line_follow_pd_steering_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULP  = 3'd1;
  localparam logic [2:0] S_MULD  = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_SPEED = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [lfps_pkg::BASE_W-1:0] base_speed;
  logic [lfps_pkg::GAIN_W-1:0] prop_gain;
  logic [lfps_pkg::GAIN_W-1:0] deriv_gain;
  logic [lfps_pkg::LIM_W-1:0]  diff_limit;

  logic signed [lfps_pkg::ERR_W-1:0] err;
  logic signed [lfps_pkg::ERR_W-1:0] prev_error;
  logic signed [lfps_pkg::ACC_W-1:0] diff;
  logic [lfps_pkg::SPEED_W-1:0] held_left;
  logic [lfps_pkg::SPEED_W-1:0] held_right;
  logic [1:0] act;

  logic [4:0] active;
  logic in_take;
  logic out_free;

  logic mac_en;
  logic mac_clear;
  logic signed [lfps_pkg::OPA_W-1:0]  mac_a;
  logic signed [lfps_pkg::DERR_W-1:0] mac_b;
  logic signed [lfps_pkg::ACC_W-1:0]  acc;

  logic signed [lfps_pkg::ACC_W-1:0] lim_pos;
  logic signed [lfps_pkg::ACC_W-1:0] lim_neg;
  logic signed [lfps_pkg::ACC_W-1:0] base_q;
  logic signed [lfps_pkg::ACC_W-1:0] sum_left;
  logic signed [lfps_pkg::ACC_W-1:0] sum_right;
  logic signed [lfps_pkg::ACC_W-1:0] diff_clamped;
  logic [lfps_pkg::SPEED_W-1:0] speed_left;
  logic [lfps_pkg::SPEED_W-1:0] speed_right;

  assign active   = ~sensor_levels;
  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // operand select for the shared multiplier
  assign mac_en    = (state == S_MULP) || (state == S_MULD);
  assign mac_clear = (state == S_MULP);
  always_comb begin
    if (state == S_MULP) begin
      mac_a = {1'b0, prop_gain};
      mac_b = {err[lfps_pkg::ERR_W-1], err};
    end else begin
      mac_a = {1'b0, deriv_gain};
      mac_b = {err[lfps_pkg::ERR_W-1], err} - {prev_error[lfps_pkg::ERR_W-1], prev_error};
    end
  end

  lfps_mac u_mac (
    .clk   (clk),
    .en    (mac_en),
    .clear (mac_clear),
    .mul_a (mac_a),
    .mul_b (mac_b),
    .acc   (acc)
  );

  assign lim_pos = {{(lfps_pkg::ACC_W-lfps_pkg::LIM_W-8){1'b0}}, diff_limit, 8'h00};
  assign lim_neg = -lim_pos;
  assign base_q  = {{(lfps_pkg::ACC_W-lfps_pkg::BASE_W-8){1'b0}}, base_speed, 8'h00};

  always_comb begin
    if (acc > lim_pos) begin
      diff_clamped = lim_pos;
    end else if (acc < lim_neg) begin
      diff_clamped = lim_neg;
    end else begin
      diff_clamped = acc;
    end
  end

  // floor at zero, then drop the fraction
  assign sum_left    = base_q + diff;
  assign sum_right   = base_q - diff;
  assign speed_left  = sum_left[lfps_pkg::ACC_W-1] ? '0 : sum_left[18:8];
  assign speed_right = sum_right[lfps_pkg::ACC_W-1] ? '0 : sum_right[18:8];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (active == 5'h1f || active == 5'h00) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MULP;
          end
        end
      end
      S_MULP:  state_next = S_MULD;
      S_MULD:  state_next = S_CLAMP;
      S_CLAMP: state_next = S_SPEED;
      S_SPEED: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      prev_error <= '0;
      held_left  <= '0;
      held_right <= '0;
      base_speed <= lfps_pkg::BASE_RESET;
      prop_gain  <= lfps_pkg::PGAIN_RESET;
      deriv_gain <= lfps_pkg::DGAIN_RESET;
      diff_limit <= lfps_pkg::LIMIT_RESET;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          lfps_pkg::REG_BASE:  base_speed <= cfg_data[lfps_pkg::BASE_W-1:0];
          lfps_pkg::REG_PGAIN: prop_gain  <= cfg_data[lfps_pkg::GAIN_W-1:0];
          lfps_pkg::REG_DGAIN: deriv_gain <= cfg_data[lfps_pkg::GAIN_W-1:0];
          lfps_pkg::REG_LIMIT: diff_limit <= cfg_data[lfps_pkg::LIM_W-1:0];
          default: ;
        endcase
      end

      if (in_take && active == 5'h1f) begin
        held_left  <= '0;
        held_right <= '0;
      end
      if (state == S_MULD) begin
        prev_error <= err;
      end
      if (state == S_SPEED) begin
        held_left  <= speed_left;
        held_right <= speed_right;
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      err <= lfps_pkg::active_error(active);
      if (active == 5'h1f) begin
        act <= lfps_pkg::ACT_STOP;
      end else if (active == 5'h00) begin
        act <= lfps_pkg::ACT_LOST;
      end else begin
        act <= lfps_pkg::ACT_TRACK;
      end
    end
    if (state == S_CLAMP) begin
      diff <= diff_clamped;
    end
    if (state == S_DONE && out_free) begin
      left_speed  <= held_left;
      right_speed <= held_right;
      action      <= act;
    end
  end

  `LFPS_ASSERT_NEXT(a_stop_zeroes, in_take && sensor_levels == 5'h00,
    state == S_DONE && act == lfps_pkg::ACT_STOP && held_left == '0 && held_right == '0,
    "full line did not zero the held speeds")
  `LFPS_ASSERT_NEXT(a_clamp_range, state == S_CLAMP,
    diff <= lim_pos && diff >= lim_neg,
    "speed difference outside limit")
  `LFPS_ASSERT_NEXT(a_prev_update, state == S_MULD,
    prev_error == $past(err) && state == S_CLAMP,
    "previous error not taken from current error")

endmodule

[verif/line_follow_pd_steering_test.sv]
// self-checking testbench for line_follow_pd_steering: sensor samples in, wheel speeds out
// predicts each result from its own pd steering calculation; needs lfps_pkg and the rtl
module line_follow_pd_steering_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPEED_W = lfps_pkg::SPEED_W;
  localparam int CIDX_W  = lfps_pkg::CIDX_W;
  localparam int CDATA_W = lfps_pkg::CDATA_W;
  localparam int BASE_W  = lfps_pkg::BASE_W;
  localparam int GAIN_W  = lfps_pkg::GAIN_W;
  localparam int LIM_W   = lfps_pkg::LIM_W;
  localparam int ERR_W   = lfps_pkg::ERR_W;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [SPEED_W-1:0] left;
    logic [SPEED_W-1:0] right;
    logic [1:0]         act;
  } wheel_cmd_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [4:0]         sensor_levels;
  logic               out_valid;
  logic               out_ready;
  logic [SPEED_W-1:0] left_speed;
  logic [SPEED_W-1:0] right_speed;
  logic [1:0]         action;
  logic               cfg_write;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  // steering model state and registers
  logic [BASE_W-1:0]        base_spd;
  logic [GAIN_W-1:0]        kp;
  logic [GAIN_W-1:0]        kd;
  logic [LIM_W-1:0]         dlim;
  logic signed [ERR_W-1:0]  last_err;
  logic [SPEED_W-1:0]       held_l;
  logic [SPEED_W-1:0]       held_r;

  wheel_cmd_t pending_speeds [$];
  int         mismatch_count;
  bit         gaps_on;
  bit         stalls_on;
  bit         hold_req;

  line_follow_pd_steering DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sensor_levels (sensor_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_speed    (left_speed),
    .right_speed   (right_speed),
    .action        (action),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic wheel_cmd_t steer_predict(input logic [4:0] levels);
    logic [4:0] seen;
    int         cnt;
    int         pos;
    int         err;
    int         diff;
    int         clamp;
    int         lspd;
    int         rspd;
    wheel_cmd_t cmd;
    seen = ~levels;
    cnt = $countones(seen);
    pos = 0;
    if (seen[0]) pos -= 3;
    if (seen[1]) pos -= 1;
    if (seen[3]) pos += 1;
    if (seen[4]) pos += 3;
    if (cnt == 5) begin
      held_l = '0;
      held_r = '0;
      cmd.act = lfps_pkg::ACT_STOP;
    end else if (cnt == 0) begin
      cmd.act = lfps_pkg::ACT_LOST;
    end else begin
      // integer divide truncates toward zero
      err = (pos * 256) / cnt;
      diff = int'(kp) * err + int'(kd) * (err - int'(last_err));
      last_err = ERR_W'(err);
      clamp = int'(dlim) * 256;
      if (diff > clamp) diff = clamp;
      if (diff < -clamp) diff = -clamp;
      lspd = int'(base_spd) * 256 + diff;
      rspd = int'(base_spd) * 256 - diff;
      held_l = (lspd < 0) ? '0 : SPEED_W'(lspd >>> 8);
      held_r = (rspd < 0) ? '0 : SPEED_W'(rspd >>> 8);
      cmd.act = lfps_pkg::ACT_TRACK;
    end
    cmd.left = held_l;
    cmd.right = held_r;
    return cmd;
  endfunction

  function automatic int next_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // mostly tracking patterns, some full line and line lost
  function automatic logic [4:0] rand_levels();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 5'b00000;
    if (r < 14) return 5'b11111;
    return 5'($urandom_range(1, 30));
  endfunction

  function automatic int rand_field(input int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;
    if (r < 40) return top;
    return $urandom_range(0, top);
  endfunction

  task automatic send_sample(input logic [4:0] levels, input int gap);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sensor_levels <= levels;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_speeds.push_back(steer_predict(levels));
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_speeds.size() != 0) @(negedge clk);
    // a full-line or lost sample may still be finishing
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk) cfg_write <= 1'b0;
    case (idx)
      lfps_pkg::REG_BASE:  base_spd = data[BASE_W-1:0];
      lfps_pkg::REG_PGAIN: kp = data[GAIN_W-1:0];
      lfps_pkg::REG_DGAIN: kd = data[GAIN_W-1:0];
      lfps_pkg::REG_LIMIT: dlim = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [BASE_W-1:0] b, input logic [GAIN_W-1:0] p,
                           input logic [GAIN_W-1:0] d, input logic [LIM_W-1:0] l);
    wait_idle();
    // writes to unused indexes must be ignored
    if ($urandom_range(0, 1))
      write_reg(lfps_pkg::REG_LIMIT + CIDX_W'($urandom_range(1, 4)), CDATA_W'($urandom));
    write_reg(lfps_pkg::REG_BASE, b);
    write_reg(lfps_pkg::REG_PGAIN, {2'($urandom_range(0, 3)), p});
    write_reg(lfps_pkg::REG_DGAIN, {2'($urandom_range(0, 3)), d});
    write_reg(lfps_pkg::REG_LIMIT, l);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_sample(rand_levels(), next_gap());
  endtask

  task automatic test_directed();
    logic [4:0] pattern [$];
    pattern = '{5'b00000, 5'b11111,                              // stop, then lost holds zero
                5'b11110, 5'b11101, 5'b11011, 5'b10111, 5'b01111, // single sensors
                5'b11111,                                         // lost after tracking
                5'b11100, 5'b00111, 5'b01110,                     // pairs
                5'b11000, 5'b00011, 5'b10100, 5'b01010,           // threes, thirds
                5'b00100, 5'b00001, 5'b10000,                     // fours
                5'b00000, 5'b11111};
    foreach (pattern[i]) send_sample(pattern[i], next_gap());
  endtask

  task automatic test_gain_extremes();
    set_gains(10'd0, 8'd0, 8'd0, 10'd0);
    run_random(80);
    set_gains(10'd1023, 8'd255, 8'd255, 10'd1023);
    run_random(80);
    set_gains(10'd1023, 8'd255, 8'd255, 10'd0);
    run_random(80);
    set_gains(10'd0, 8'd255, 8'd255, 10'd1023);
    run_random(80);
    set_gains(10'd1023, 8'd0, 8'd0, 10'd1023);
    run_random(80);
    set_gains(10'd512, 8'd0, 8'd255, 10'd1023);
    run_random(80);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 11; ph++) begin
      set_gains(BASE_W'(rand_field(1023)), GAIN_W'(rand_field(255)),
                GAIN_W'(rand_field(255)), LIM_W'(rand_field(1023)));
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      run_random(100);
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // receiver holds off while samples keep coming back to back
  task automatic test_backpressure();
    wait_idle();
    @(posedge clk) hold_req = 1'b1;
    gaps_on = 1'b0;
    run_random(40);
    gaps_on = 1'b1;
  endtask

  // result receiver ready
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && stalls_on) begin
        r = $urandom_range(0, 99);
        if (r < 60) stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else if (r < 98) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(20, 60);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    wheel_cmd_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_speeds.size() == 0) begin
        $error("result request with no sample pending: left %0d right %0d action %0d",
               left_speed, right_speed, action);
        mismatch_count++;
      end else begin
        want = pending_speeds.pop_front();
        if (left_speed !== want.left) begin
          $error("left_speed expected %0d actual %0d", want.left, left_speed);
          mismatch_count++;
        end
        if (right_speed !== want.right) begin
          $error("right_speed expected %0d actual %0d", want.right, right_speed);
          mismatch_count++;
        end
        if (action !== want.act) begin
          $error("action expected %0d actual %0d", want.act, action);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sensor_levels = '1;
    cfg_write = 1'b0;
    cfg_index = lfps_pkg::REG_BASE;
    cfg_data = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 1'b0;
    mismatch_count = 0;
    base_spd = lfps_pkg::BASE_RESET;
    kp = lfps_pkg::PGAIN_RESET;
    kd = lfps_pkg::DGAIN_RESET;
    dlim = lfps_pkg::LIMIT_RESET;
    last_err = '0;
    held_l = '0;
    held_r = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed();
    test_gain_extremes();
    test_random_settings();
    test_backpressure();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_speeds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lfps_pkg.sv
hw/rtl/lfps_mac.sv
hw/rtl/line_follow_pd_steering.sv
verif/line_follow_pd_steering_test.sv
